// ===== hdl/lfu_set_assoc_cache_tags_assert.svh =====
// Assertion macros shared by the checker of the LFU cache tag block.
// Depends on nothing.
`ifndef LFU_SET_ASSOC_CACHE_TAGS_ASSERT_SVH
`define LFU_SET_ASSOC_CACHE_TAGS_ASSERT_SVH
`define LCT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lct check failed");
`define LCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lct check failed");
`endif

// ===== hdl/lct_pkg.sv =====
// Package for the LFU cache tag block: sizes, command codes and state types.
// Depends on nothing.
`timescale 1ns / 1ps
package lct_pkg;
  localparam int Sets = 256;
  localparam int Ways = 4;
  localparam int SetW = $clog2(Sets) > 0 ? $clog2(Sets) : 1;
  localparam int WayW = $clog2(Ways) > 0 ? $clog2(Ways) : 1;
  localparam int WayCntW = $clog2(Ways + 1);
  localparam int Lines = Sets * Ways;
  localparam int LineW = $clog2(Lines);
  localparam int TagW = 61;
  localparam int EntW = TagW + 2;
  localparam int CntW = 32;
  localparam logic [3:0] MaxIdx = 4'($clog2(Sets));
  localparam logic [3:0] ShMin = 4'd3;
  localparam logic [3:0] ShMax = 4'd12;
  localparam logic CfgLine = 1'b0;
  localparam logic CfgSets = 1'b1;

  typedef enum logic [2:0] {
    CmdRead = 3'd0, CmdWrite = 3'd1, CmdClean = 3'd2, CmdInval = 3'd3, CmdCleanInval = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    StIdle, StRead, StScan, StFetch, StUpdate, StOut
  } state_e;

  typedef struct packed {
    logic           valid;
    logic           dirty;
    logic [TagW-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic [WayW-1:0] hit_way;
    logic [WayW-1:0] victim;
  } scan_t;
endpackage

// ===== hdl/lct_ram.sv =====
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
module lct_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// ===== hdl/lct_scan.sv =====
// Way-by-way compare unit: one tag compare and one count compare per cycle while step_i is high.
// Depends on lct_pkg.
`timescale 1ns / 1ps
module lct_scan import lct_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            step_i,
  input  logic [WayW-1:0] way_i,
  input  entry_t          ent_i,
  input  logic [CntW-1:0] cnt_i,
  input  logic [TagW-1:0] tag_i,
  output scan_t           res_o
);
  scan_t res_q, res_d;
  logic [CntW-1:0] min_q, min_d;
  always_comb begin
    res_d = res_q;
    min_d = min_q;
    if (start_i) begin
      res_d = '0;
      min_d = '1;
    end else if (step_i) begin
      if (ent_i.valid && ent_i.tag == tag_i && !res_q.found) begin
        res_d.found = 1'b1;
        res_d.hit_way = way_i;
      end
      if (way_i == '0 || cnt_i < min_q) begin
        res_d.victim = way_i;
        min_d = cnt_i;
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
      min_q <= '0;
    end else begin
      res_q <= res_d;
      min_q <= min_d;
    end
  end
  assign res_o = res_q;
endmodule

// ===== hdl/lfu_set_assoc_cache_tags.sv =====
// Top level of the LFU set-associative cache tag and policy block.
// Depends on lct_pkg, lct_ram and lct_scan.
//
//  channel | valid / ready          | payload
//  in      | in_valid_i / in_ready_o | command_i, address_i
//  out     | out_valid_o / out_ready_i | hit_o, writeback_*, fill_*
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// After a word is taken, the tag and count
// RAMs are read one way a cycle through a single port, the chosen way is read again
// and then written. The result then shows until out_ready_i is high, and the block
// returns to idle; no new word is taken until the last one has left.
// After reset a clearing pass over all Lines entries (1024) runs; no word is taken then.
// A result held while out_ready_i is low delays the next word.
`timescale 1ns / 1ps
module lfu_set_assoc_cache_tags import lct_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [63:0] address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic        writeback_valid_o,
  output logic [63:0] writeback_address_o,
  output logic        fill_valid_o,
  output logic [63:0] fill_address_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i
);
  state_e state_q, state_d;
  logic [3:0] lsl_q, sib_q;
  logic [2:0] cmd_q;
  logic [TagW-1:0] tag_q;
  logic [SetW-1:0] set_q;
  logic [WayCntW-1:0] way_q, way_d;
  logic [LineW:0] clr_q;
  logic clearing;
  logic [WayW-1:0] rd_way_q;
  logic rd_vld_q;
  logic [3:0] sh, sb;
  logic [63:0] line_addr;
  logic [SetW-1:0] set_mask;
  logic we;
  logic [LineW-1:0] ram_addr;
  entry_t ent_w, ent_r;
  logic [CntW-1:0] cnt_w, cnt_r;
  logic [EntW-1:0] ent_raw;
  scan_t scan;
  logic hit_q, wbv_q, fv_q;
  logic [TagW-1:0] wbt_q;
  logic [3:0] osh_q;

  assign clearing = !clr_q[LineW];
  assign sh = (lsl_q < ShMin) ? ShMin : (lsl_q > ShMax) ? ShMax : lsl_q;
  assign sb = (sib_q > MaxIdx) ? MaxIdx : sib_q;
  assign line_addr = address_i >> sh;
  always_comb begin
    set_mask = '0;
    for (int i = 0; i < SetW; i++) begin
      set_mask[i] = (4'(i) < sb);
    end
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (state_q == StIdle) && !clearing;
  assign out_valid_o = (state_q == StOut);
  assign ent_r = entry_t'(ent_raw);

  logic [WayW-1:0] upd_way;
  logic do_write;
  always_comb begin
    state_d = state_q;
    way_d = way_q;
    we = 1'b0;
    ram_addr = {set_q, way_q[WayW-1:0]};
    ent_w = ent_r;
    cnt_w = cnt_r;
    upd_way = scan.found ? scan.hit_way : scan.victim;
    do_write = 1'b0;
    case (state_q)
      StIdle: begin
        if (clearing) begin
          we = 1'b1;
          ram_addr = clr_q[LineW-1:0];
          ent_w = '0;
          cnt_w = '0;
        end else if (in_valid_i) begin
          way_d = '0;
          state_d = StRead;
        end
      end
      StRead: begin
        way_d = way_q + 1'b1;
        if (way_q == WayCntW'(Ways - 1)) begin
          state_d = StScan;
        end
      end
      StScan: begin
        state_d = StFetch;
      end
      StFetch: begin
        ram_addr = {set_q, upd_way};
        state_d = StUpdate;
      end
      StUpdate: begin
        ram_addr = {set_q, upd_way};
        if (cmd_q == CmdRead || cmd_q == CmdWrite) begin
          do_write = 1'b1;
          if (scan.found) begin
            if (cnt_r != '1) cnt_w = cnt_r + 1'b1;
            if (cmd_q == CmdWrite) ent_w.dirty = 1'b1;
          end else begin
            cnt_w = 32'd1;
            ent_w.valid = 1'b1;
            ent_w.dirty = (cmd_q == CmdWrite);
            ent_w.tag = tag_q;
          end
        end else if (scan.found && cmd_q <= CmdCleanInval) begin
          do_write = 1'b1;
          if (cmd_q != CmdInval) ent_w.dirty = 1'b0;
          if (cmd_q != CmdClean) begin
            ent_w.valid = 1'b0;
            ent_w.dirty = 1'b0;
          end
        end
        we = do_write;
        state_d = StOut;
      end
      StOut: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  lct_ram #(.Width(EntW), .Depth(Lines)) u_tag_ram (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(EntW'(ent_w)), .rdata_o(ent_raw)
  );
  lct_ram #(.Width(CntW), .Depth(Lines)) u_cnt_ram (
    .clk_i, .we_i(we), .addr_i(ram_addr), .wdata_i(cnt_w), .rdata_o(cnt_r)
  );
  lct_scan u_scan (
    .clk_i, .rst_ni, .start_i(state_q == StIdle), .step_i(rd_vld_q), .way_i(rd_way_q),
    .ent_i(ent_r), .cnt_i(cnt_r), .tag_i(tag_q), .res_o(scan)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lsl_q <= 4'd6;
      sib_q <= 4'd8;
      clr_q <= '0;
      way_q <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      way_q <= way_d;
      rd_vld_q <= (state_q == StRead);
      if (clearing) clr_q <= clr_q + 1'b1;
      if (cfg_valid_i) begin
        if (cfg_index_i == CfgLine) lsl_q <= cfg_data_i;
        else lsl_q <= lsl_q;
        if (cfg_index_i == CfgSets) sib_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_way_q <= way_q[WayW-1:0];
    if (in_valid_i && in_ready_o) begin
      cmd_q <= command_i;
      tag_q <= line_addr[TagW-1:0];
      set_q <= line_addr[SetW-1:0] & set_mask;
      osh_q <= sh;
    end
    if (state_q == StUpdate) begin
      hit_q <= 1'b0;
      wbv_q <= 1'b0;
      fv_q <= 1'b0;
      wbt_q <= ent_r.tag;
      if (cmd_q == CmdRead || cmd_q == CmdWrite) begin
        hit_q <= scan.found;
        fv_q <= !scan.found;
        wbv_q <= !scan.found && ent_r.valid && ent_r.dirty;
      end else if (cmd_q <= CmdCleanInval && scan.found) begin
        hit_q <= 1'b1;
        wbv_q <= (cmd_q != CmdInval) && ent_r.dirty;
      end
    end
  end

  assign hit_o = hit_q;
  assign writeback_valid_o = wbv_q;
  assign fill_valid_o = fv_q;
  assign writeback_address_o = wbv_q ? ({3'b000, wbt_q} << osh_q) : 64'd0;
  assign fill_address_o = fv_q ? ({3'b000, tag_q} << osh_q) : 64'd0;
endmodule

// ===== hdl/lct_checker.sv =====
// Port-level checker for the LFU cache tag block, bound to the top level.
// Depends on lfu_set_assoc_cache_tags_assert.svh.
`timescale 1ns / 1ps
`include "lfu_set_assoc_cache_tags_assert.svh"
module lct_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic hit_o,
  input logic writeback_valid_o,
  input logic fill_valid_o
);
  `LCT_ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, out_valid_o, !in_ready_o)
  `LCT_ASSERT_IMPL(a_fill_miss, clk_i, rst_ni, out_valid_o && fill_valid_o, !hit_o)
  `LCT_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `LCT_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
endmodule

bind lfu_set_assoc_cache_tags lct_checker u_lct_checker (.*);

// ===== bench/tb.sv =====
// Self-checking testbench for the LFU set-associative cache tag block.
// Depends on lct_pkg and lfu_set_assoc_cache_tags; it models tags, counts and settings itself.
`timescale 1ns / 1ps
module tb;
  import lct_pkg::*;

  localparam int StallLimit = 6000;

  typedef struct {
    logic [2:0]  cmd;
    logic [63:0] addr;
  } access_t;

  typedef struct {
    logic        hit;
    logic        wb_valid;
    logic [63:0] wb_addr;
    logic        fill_valid;
    logic [63:0] fill_addr;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = '0;
  logic [63:0] address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        hit_o;
  logic        writeback_valid_o;
  logic [63:0] writeback_address_o;
  logic        fill_valid_o;
  logic [63:0] fill_address_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [0:0]  cfg_index_i = CfgLine;
  logic [3:0]  cfg_data_i = '0;

  lfu_set_assoc_cache_tags dut (.*);

  always #6 clk_i = ~clk_i;

  logic        line_valid [Lines];
  logic        line_dirty [Lines];
  logic [63:0] line_tag [Lines];
  logic [31:0] use_count [Lines];
  logic [3:0]  line_shift_reg = 4'd6;
  logic [3:0]  index_bits_reg = 4'd8;

  access_t  pending_words [$];
  outcome_t expected_outcomes [$];
  int       words_taken = 0;
  int       mismatches = 0;
  int       stall_cycles = 0;
  logic     in_taken = 1'b0;
  logic     quiet;
  logic [63:0] tag_pool [8];

  assign quiet = words_taken >= 300 && words_taken < 450;

  function automatic outcome_t predict_lookup(access_t a);
    outcome_t r;
    int unsigned sh, b, base, way, vic, e;
    logic [63:0] tg;
    r = '{1'b0, 1'b0, 64'd0, 1'b0, 64'd0};
    if (a.cmd > CmdCleanInval) return r;
    sh = line_shift_reg < 3 ? 3 : (line_shift_reg > 12 ? 12 : line_shift_reg);
    b = index_bits_reg > $clog2(Sets) ? $clog2(Sets) : index_bits_reg;
    tg = a.addr >> sh;
    base = int'(tg & ((64'd1 << b) - 1)) * Ways;
    way = Ways;
    for (int w = Ways - 1; w >= 0; w--)
      if (line_valid[base + w] && line_tag[base + w] == tg) way = w;
    if (a.cmd == CmdRead || a.cmd == CmdWrite) begin
      if (way < Ways) begin
        e = base + way;
        r.hit = 1'b1;
        if (use_count[e] != 32'hFFFF_FFFF) use_count[e]++;
        if (a.cmd == CmdWrite) line_dirty[e] = 1'b1;
      end else begin
        vic = 0;
        for (int w = 1; w < Ways; w++)
          if (use_count[base + w] < use_count[base + vic]) vic = w;
        e = base + vic;
        if (line_valid[e] && line_dirty[e]) begin
          r.wb_valid = 1'b1;
          r.wb_addr = line_tag[e] << sh;
        end
        use_count[e] = 32'd1;
        line_valid[e] = 1'b1;
        line_dirty[e] = a.cmd == CmdWrite;
        line_tag[e] = tg;
        r.fill_valid = 1'b1;
        r.fill_addr = tg << sh;
      end
    end else if (way < Ways) begin
      e = base + way;
      r.hit = 1'b1;
      if (a.cmd != CmdInval && line_dirty[e]) begin
        r.wb_valid = 1'b1;
        r.wb_addr = line_tag[e] << sh;
        line_dirty[e] = 1'b0;
      end
      if (a.cmd != CmdClean) begin
        line_valid[e] = 1'b0;
        line_dirty[e] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic access_t random_access();
    access_t a;
    int unsigned r, sh, b;
    r = $urandom_range(0, 99);
    if (r < 5) a.cmd = 3'($urandom_range(5, 7));
    else if (r < 40) a.cmd = CmdRead;
    else if (r < 75) a.cmd = CmdWrite;
    else if (r < 85) a.cmd = CmdClean;
    else if (r < 93) a.cmd = CmdInval;
    else a.cmd = CmdCleanInval;
    sh = line_shift_reg < 3 ? 3 : (line_shift_reg > 12 ? 12 : line_shift_reg);
    b = index_bits_reg > 8 ? 8 : index_bits_reg;
    if ($urandom_range(0, 99) < 10) a.addr = {$urandom, $urandom};
    else a.addr = (tag_pool[$urandom_range(0, 7)] << (sh + b))
                | (64'($urandom_range(0, 3)) << sh) | (64'($urandom) & ((64'd1 << sh) - 1));
    return a;
  endfunction

  always @(posedge clk_i) begin
    outcome_t exp_o;
    in_taken <= in_valid_i && in_ready_o;
    if (in_valid_i && in_ready_o) begin
      expected_outcomes.push_back(predict_lookup('{command_i, address_i}));
      words_taken++;
    end
    if (out_valid_o && out_ready_i) begin
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word at %0t.", $realtime);
      end else begin
        exp_o = expected_outcomes.pop_front();
        if (hit_o !== exp_o.hit || writeback_valid_o !== exp_o.wb_valid
            || writeback_address_o !== exp_o.wb_addr || fill_valid_o !== exp_o.fill_valid
            || fill_address_o !== exp_o.fill_addr) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at %0t: expected hit %0b wb %0b/%h fill %0b/%h, got %0b %0b/%h %0b/%h",
                     $realtime, exp_o.hit, exp_o.wb_valid, exp_o.wb_addr, exp_o.fill_valid,
                     exp_o.fill_addr, hit_o, writeback_valid_o, writeback_address_o,
                     fill_valid_o, fill_address_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    access_t a;
    if (rst_ni) begin
      out_ready_i <= quiet || $urandom_range(0, 99) >= 15;
      if (!in_valid_i || in_taken) begin
        if (pending_words.size() > 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
          a = pending_words.pop_front();
          command_i <= a.cmd;
          address_i <= a.addr;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
          || (cfg_valid_i && cfg_ready_o)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic drain();
    wait (pending_words.size() == 0 && !in_valid_i && expected_outcomes.size() == 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [3:0] data);
    @(negedge clk_i);
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgLine) line_shift_reg = data;
    else index_bits_reg = data;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    logic [3:0] line_cfg [6] = '{4'd3, 4'd12, 4'd0, 4'd15, 4'd9, 4'd6};
    logic [3:0] sets_cfg [6] = '{4'd0, 4'd8, 4'd15, 4'd2, 4'd4, 4'd8};
    for (int i = 0; i < Lines; i++) begin
      line_valid[i] = 1'b0;
      line_dirty[i] = 1'b0;
      line_tag[i] = '0;
      use_count[i] = '0;
    end
    for (int i = 0; i < 8; i++) tag_pool[i] = {$urandom, $urandom};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    pending_words.push_back('{CmdRead, 64'h1000});
    pending_words.push_back('{CmdRead, 64'h1008});
    pending_words.push_back('{CmdWrite, 64'h1010});
    pending_words.push_back('{CmdClean, 64'h1000});
    pending_words.push_back('{CmdClean, 64'h1000});
    pending_words.push_back('{CmdWrite, 64'h1000});
    pending_words.push_back('{CmdCleanInval, 64'h1000});
    pending_words.push_back('{CmdRead, 64'h1000});
    pending_words.push_back('{CmdInval, 64'h1000});
    pending_words.push_back('{CmdClean, 64'h1000});
    pending_words.push_back('{CmdInval, 64'h1000});
    pending_words.push_back('{3'd5, 64'h2000});
    pending_words.push_back('{3'd6, '1});
    pending_words.push_back('{3'd7, 64'h0});
    pending_words.push_back('{CmdRead, '1});
    pending_words.push_back('{CmdWrite, '1});
    pending_words.push_back('{CmdWrite, 64'h0});
    for (int k = 1; k <= 6; k++) pending_words.push_back('{CmdWrite, 64'(k) << 14});
    pending_words.push_back('{CmdCleanInval, '1});
    for (int i = 0; i < 180; i++) pending_words.push_back(random_access());
    drain();
    for (int p = 0; p < 6; p++) begin
      write_reg(CfgLine, line_cfg[p]);
      write_reg(CfgSets, sets_cfg[p]);
      for (int i = 0; i < 125; i++) pending_words.push_back(random_access());
      drain();
    end
    if (mismatches == 0 && expected_outcomes.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
